// ===== rtl/core/dod_pkg.sv =====
// Package with types, constants and calendar functions for the date offset block.
package dod_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 12;

    localparam logic [YEAR_W-1:0]   YEAR_MIN   = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]   YEAR_MAX   = YEAR_W'(9999);
    localparam logic [OFFSET_W-1:0] MAX_OFFSET = OFFSET_W'(4095);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAY_LONG  = DAY_W'(31);

    // Reciprocal of one hundred, scaled by two to the power LEAP_SHIFT.
    localparam int RECIP_W    = 13;
    localparam int LEAP_SHIFT = 19;
    localparam int PROD_W     = YEAR_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - LEAP_SHIFT;
    localparam logic [RECIP_W-1:0] LEAP_RECIP = RECIP_W'(5243);
    localparam logic [6:0]         CENTURY    = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP_MUL,
        ST_LEAP_FIN,
        ST_CLAMP,
        ST_STEP,
        ST_DONE
    } state_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4:      len = DAY_W'(30);
            4'd6:      len = DAY_W'(30);
            4'd9:      len = DAY_W'(30);
            4'd11:     len = DAY_W'(30);
            default:   len = DAY_LONG;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/dod_leap.sv =====
// Two-stage leap-year unit using a reciprocal multiplication for the century test.
module dod_leap (
    input  logic                      clk,
    input  logic [dod_pkg::YEAR_W-1:0] year,
    output logic                      leap
);

    logic [dod_pkg::PROD_W-1:0] prod_reg;
    logic [dod_pkg::QUOT_W-1:0] quot;
    logic [dod_pkg::YEAR_W-1:0] rem;
    logic                       leap_reg;
    logic                       leap_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= dod_pkg::PROD_W'(year) * dod_pkg::PROD_W'(dod_pkg::LEAP_RECIP);
        leap_reg <= leap_next;
    end

    always_comb
    begin
        quot = prod_reg[dod_pkg::PROD_W-1:dod_pkg::LEAP_SHIFT];
        rem  = year - (dod_pkg::YEAR_W'(quot) * dod_pkg::YEAR_W'(dod_pkg::CENTURY));
        if (rem != '0)
        begin
            leap_next = (year[1:0] == 2'd0);
        end
        else
        begin
            leap_next = (quot[1:0] == 2'd0);
        end
    end

    assign leap = leap_reg;

endmodule

// ===== rtl/core/date_offset_by_days_top.sv =====
// Top level of the date offset block: sequencer and day stepping datapath.
//
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          command, start_day, start_month,
//                                             start_year, offset_days
// result    out        done, one cycle        end_day, end_month, end_year,
//                                             out_of_range
//
// After the accepting edge the sequencer runs ST_LEAP_MUL, ST_LEAP_FIN, ST_CLAMP, then
// ST_STEP and ST_DONE; a year boundary sends it back to ST_LEAP_MUL while the leap-year
// unit recomputes. The day stepper handles one day per cycle while in ST_STEP. Reset
// clears the sequencer only. busy falls once the strobe cycle has passed, so the next
// transaction can be accepted in the cycle after the strobe; the receiver cannot stall.
module date_offset_by_days_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [dod_pkg::DAY_W-1:0]     start_day,
    input  logic [dod_pkg::MONTH_W-1:0]   start_month,
    input  logic [dod_pkg::YEAR_W-1:0]    start_year,
    input  logic [dod_pkg::OFFSET_W-1:0]  offset_days,
    output logic                          done,
    output logic [dod_pkg::DAY_W-1:0]     end_day,
    output logic [dod_pkg::MONTH_W-1:0]   end_month,
    output logic [dod_pkg::YEAR_W-1:0]    end_year,
    output logic                          out_of_range
);

    dod_pkg::state_t state_reg, state_next;

    logic                          back_reg;
    logic [dod_pkg::DAY_W-1:0]     day_reg, day_next;
    logic [dod_pkg::MONTH_W-1:0]   month_reg, month_next;
    logic [dod_pkg::YEAR_W-1:0]    year_reg, year_next;
    logic [dod_pkg::OFFSET_W-1:0]  cnt_reg, cnt_next;
    logic                          flag_reg, flag_next;
    logic                          leap;
    logic [dod_pkg::DAY_W-1:0]     cur_len;
    logic [dod_pkg::DAY_W-1:0]     prev_len;
    logic                          year_change;
    logic                          at_limit;

    dod_leap u_leap (
        .clk  (clk),
        .year (year_reg),
        .leap (leap)
    );

    assign cur_len  = dod_pkg::month_days(month_reg, leap);
    assign prev_len = dod_pkg::month_days(month_reg - dod_pkg::MONTH_W'(1), leap);

    always_comb
    begin
        year_change = 1'b0;
        at_limit    = 1'b0;
        if (!back_reg)
        begin
            if (day_reg >= cur_len && month_reg >= dod_pkg::MONTH_DEC)
            begin
                year_change = (year_reg < dod_pkg::YEAR_MAX);
                at_limit    = !(year_reg < dod_pkg::YEAR_MAX);
            end
        end
        else
        begin
            if (day_reg <= dod_pkg::DAY_FIRST && month_reg <= dod_pkg::MONTH_JAN)
            begin
                year_change = (year_reg > dod_pkg::YEAR_MIN);
                at_limit    = !(year_reg > dod_pkg::YEAR_MIN);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dod_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = dod_pkg::ST_LEAP_MUL;
                end
            end
            dod_pkg::ST_LEAP_MUL: state_next = dod_pkg::ST_LEAP_FIN;
            dod_pkg::ST_LEAP_FIN: state_next = dod_pkg::ST_CLAMP;
            dod_pkg::ST_CLAMP:    state_next = dod_pkg::ST_STEP;
            dod_pkg::ST_STEP:
            begin
                if (cnt_reg == '0 || at_limit)
                begin
                    state_next = dod_pkg::ST_DONE;
                end
                else if (year_change)
                begin
                    state_next = dod_pkg::ST_LEAP_MUL;
                end
            end
            dod_pkg::ST_DONE:     state_next = dod_pkg::ST_IDLE;
            default:              state_next = dod_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cnt_next   = cnt_reg;
        flag_next  = flag_reg;
        case (state_reg)
            dod_pkg::ST_IDLE:
            begin
                day_next   = start_day;
                month_next = start_month;
                year_next  = start_year;
                cnt_next   = offset_days;
                flag_next  = 1'b0;
                if (start_month < dod_pkg::MONTH_JAN)
                begin
                    month_next = dod_pkg::MONTH_JAN;
                end
                else if (start_month > dod_pkg::MONTH_DEC)
                begin
                    month_next = dod_pkg::MONTH_DEC;
                end
                if (start_year < dod_pkg::YEAR_MIN)
                begin
                    year_next = dod_pkg::YEAR_MIN;
                end
                else if (start_year > dod_pkg::YEAR_MAX)
                begin
                    year_next = dod_pkg::YEAR_MAX;
                end
                if (start_day < dod_pkg::DAY_FIRST)
                begin
                    day_next = dod_pkg::DAY_FIRST;
                end
                if (offset_days > dod_pkg::MAX_OFFSET)
                begin
                    cnt_next = dod_pkg::MAX_OFFSET;
                end
            end
            dod_pkg::ST_CLAMP:
            begin
                if (day_reg > cur_len)
                begin
                    day_next = cur_len;
                end
            end
            dod_pkg::ST_STEP:
            begin
                if (cnt_reg != '0)
                begin
                    if (at_limit)
                    begin
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - dod_pkg::OFFSET_W'(1);
                        if (!back_reg)
                        begin
                            if (day_reg < cur_len)
                            begin
                                day_next = day_reg + dod_pkg::DAY_W'(1);
                            end
                            else if (month_reg < dod_pkg::MONTH_DEC)
                            begin
                                day_next   = dod_pkg::DAY_FIRST;
                                month_next = month_reg + dod_pkg::MONTH_W'(1);
                            end
                            else
                            begin
                                day_next   = dod_pkg::DAY_FIRST;
                                month_next = dod_pkg::MONTH_JAN;
                                year_next  = year_reg + dod_pkg::YEAR_W'(1);
                            end
                        end
                        else
                        begin
                            if (day_reg > dod_pkg::DAY_FIRST)
                            begin
                                day_next = day_reg - dod_pkg::DAY_W'(1);
                            end
                            else if (month_reg > dod_pkg::MONTH_JAN)
                            begin
                                month_next = month_reg - dod_pkg::MONTH_W'(1);
                                day_next   = prev_len;
                            end
                            else
                            begin
                                // December always has 31 days, whatever the year.
                                month_next = dod_pkg::MONTH_DEC;
                                day_next   = dod_pkg::DAY_LONG;
                                year_next  = year_reg - dod_pkg::YEAR_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dod_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == dod_pkg::ST_IDLE)
        begin
            back_reg <= command;
        end
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        cnt_reg   <= cnt_next;
        flag_reg  <= flag_next;
    end

    always_comb
    begin
        busy = (state_reg != dod_pkg::ST_IDLE);
        done = (state_reg == dod_pkg::ST_DONE);
    end

    assign end_day      = day_reg;
    assign end_month    = month_reg;
    assign end_year     = year_reg;
    assign out_of_range = flag_reg;

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after the done strobe");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dod_pkg::ST_STEP && cnt_reg != '0 && !at_limit)
        |=> cnt_reg == $past(cnt_reg) - dod_pkg::OFFSET_W'(1))
        else $error("day counter did not advance by one step");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (end_day >= dod_pkg::DAY_FIRST && end_month >= dod_pkg::MONTH_JAN
                  && end_month <= dod_pkg::MONTH_DEC && end_year >= dod_pkg::YEAR_MIN
                  && end_year <= dod_pkg::YEAR_MAX))
        else $error("result date outside the legal range");

endmodule
